### sv/ipvp_pkg.sv
// ----------------------------------------------------------------------------
// ipvp_pkg
// Types and constants of the IPv4 TCP/UDP port filter parser.
// ----------------------------------------------------------------------------
package ipvp_pkg;

  localparam int MaxFrameBytesDef = 65536;
  localparam int PosMax           = 65535;
  localparam int CfgIdxW          = 1;
  localparam int CfgDataW         = 16;

  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;
  localparam logic [15:0] LoopHdr   = 16'd4;
  localparam logic [15:0] EthHdr    = 16'd14;
  localparam logic [15:0] IpMinLen  = 16'd20;
  localparam logic [15:0] TcpMinLen = 16'd20;
  localparam logic [15:0] UdpHdrLen = 16'd8;
  localparam logic [3:0]  MinWords  = 4'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLinkType   = 1'b0,
    CfgTargetPort = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StAccepted     = 3'd0,
    StTooShort     = 3'd1,
    StBadIhl       = 3'd2,
    StOtherProto   = 3'd3,
    StL4Short      = 3'd4,
    StPortMismatch = 3'd5
  } status_e;

  localparam logic KindPayload = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [2:0]  status;
    logic [7:0]  l4_protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] payload_length;
  } out_word_t;

  typedef struct packed {
    logic pay_vld;
    logic sum_vld;
  } push_t;

endpackage

### sv/ipvp_parser.sv
// ----------------------------------------------------------------------------
// ipvp_parser
// Per-byte header capture, payload filter and end-of-frame summary.
// ----------------------------------------------------------------------------
module ipvp_parser #(
  parameter int MaxFrameBytes = ipvp_pkg::MaxFrameBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  ipvp_pkg::in_word_t  in_i,
  input  logic                link_type_i,
  input  logic [15:0]         target_port_i,
  output ipvp_pkg::push_t     push_o,
  output ipvp_pkg::out_word_t pay_o,
  output ipvp_pkg::out_word_t sum_o
);
  import ipvp_pkg::*;

  localparam int CapInt = (MaxFrameBytes < PosMax) ? MaxFrameBytes : PosMax;
  localparam logic [15:0] Cap = 16'(CapInt);

  logic [15:0] pos_q, pos_d;
  logic [3:0]  hw_q, hw_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_addr_q, src_addr_d;
  logic [31:0] dst_addr_q, dst_addr_d;
  logic [15:0] src_port_q, src_port_d;
  logic [15:0] dst_port_q, dst_port_d;
  logic [3:0]  tcp_off_q, tcp_off_d;
  logic [15:0] cnt_q, cnt_d;

  logic [15:0] l2, q, r, hdr, hw_bytes, ip_len, l4_len;
  logic [7:0]  b;
  logic        l4_on, has_pay, emit, proto_ok, is_tcp, is_udp, match;
  status_e     st;

  assign b  = in_i.frame_byte;
  assign l2 = link_type_i ? EthHdr : LoopHdr;

  always_comb begin
    pos_d      = pos_q;
    hw_d       = hw_q;
    proto_d    = proto_q;
    src_addr_d = src_addr_q;
    dst_addr_d = dst_addr_q;
    src_port_d = src_port_q;
    dst_port_d = dst_port_q;
    tcp_off_d  = tcp_off_q;
    cnt_d      = cnt_q;
    q          = pos_q - l2;
    r          = '0;
    hdr        = '0;
    l4_on      = 1'b0;
    has_pay    = 1'b0;
    emit       = 1'b0;
    if (pos_q < Cap) begin
      if (pos_q >= l2) begin
        unique case (q)
          16'd0:   hw_d = b[3:0];
          16'd9:   proto_d = b;
          16'd12:  src_addr_d[31:24] = src_addr_q[31:24] | b;
          16'd13:  src_addr_d[23:16] = src_addr_q[23:16] | b;
          16'd14:  src_addr_d[15:8]  = src_addr_q[15:8]  | b;
          16'd15:  src_addr_d[7:0]   = src_addr_q[7:0]   | b;
          16'd16:  dst_addr_d[31:24] = dst_addr_q[31:24] | b;
          16'd17:  dst_addr_d[23:16] = dst_addr_q[23:16] | b;
          16'd18:  dst_addr_d[15:8]  = dst_addr_q[15:8]  | b;
          16'd19:  dst_addr_d[7:0]   = dst_addr_q[7:0]   | b;
          default: ;
        endcase
        l4_on = (hw_d >= MinWords) && (q >= {10'd0, hw_d, 2'b00}) &&
                (proto_d == ProtoTcp || proto_d == ProtoUdp);
        r = q - {10'd0, hw_d, 2'b00};
        if (l4_on) begin
          unique case (r)
            16'd0:   src_port_d[15:8] = src_port_q[15:8] | b;
            16'd1:   src_port_d[7:0]  = src_port_q[7:0]  | b;
            16'd2:   dst_port_d[15:8] = dst_port_q[15:8] | b;
            16'd3:   dst_port_d[7:0]  = dst_port_q[7:0]  | b;
            default: ;
          endcase
          if (proto_d == ProtoTcp && r == 16'd12) begin
            tcp_off_d = b[7:4];
          end
          if (proto_d == ProtoUdp) begin
            hdr     = UdpHdrLen;
            has_pay = 1'b1;
          end else if (r >= TcpMinLen && tcp_off_d >= MinWords) begin
            hdr     = {10'd0, tcp_off_d, 2'b00};
            has_pay = 1'b1;
          end
          emit = has_pay && (r >= hdr) && (r >= 16'd4) &&
                 (src_port_d == target_port_i || dst_port_d == target_port_i);
        end
        if (emit && cnt_q != 16'(PosMax)) begin
          cnt_d = cnt_q + 16'd1;
        end
      end
      pos_d = pos_q + 16'd1;
    end
  end

  assign is_tcp   = (proto_d == ProtoTcp);
  assign is_udp   = (proto_d == ProtoUdp);
  assign proto_ok = is_tcp || is_udp;
  assign match    = (src_port_d == target_port_i) || (dst_port_d == target_port_i);
  assign hw_bytes = {10'd0, hw_d, 2'b00};
  assign ip_len   = pos_d - l2;
  assign l4_len   = ip_len - hw_bytes;

  always_comb begin
    priority if ({1'b0, pos_d} < ({1'b0, l2} + {1'b0, IpMinLen})) begin
      st = StTooShort;
    end else if (hw_d < MinWords || hw_bytes > ip_len) begin
      st = StBadIhl;
    end else if (!proto_ok) begin
      st = StOtherProto;
    end else if ((is_tcp && l4_len < TcpMinLen) || (is_udp && l4_len < UdpHdrLen)) begin
      st = StL4Short;
    end else if (!match) begin
      st = StPortMismatch;
    end else begin
      st = StAccepted;
    end
  end

  always_comb begin
    pay_o              = '0;
    pay_o.out_kind     = KindPayload;
    pay_o.payload_byte = b;
    pay_o.payload_last = in_i.frame_end;

    sum_o                = '0;
    sum_o.out_kind       = KindSummary;
    sum_o.status         = st;
    sum_o.l4_protocol    = proto_d;
    sum_o.source_address = src_addr_d;
    sum_o.dest_address   = dst_addr_d;
    sum_o.source_port    = src_port_d;
    sum_o.dest_port      = dst_port_d;
    sum_o.payload_length = (st == StAccepted) ? cnt_d : 16'd0;
  end

  assign push_o.pay_vld = accept_i && emit;
  assign push_o.sum_vld = accept_i && in_i.frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      hw_q       <= '0;
      proto_q    <= '0;
      src_addr_q <= '0;
      dst_addr_q <= '0;
      src_port_q <= '0;
      dst_port_q <= '0;
      tcp_off_q  <= '0;
      cnt_q      <= '0;
    end else if (accept_i) begin
      if (in_i.frame_end) begin
        pos_q      <= '0;
        hw_q       <= '0;
        proto_q    <= '0;
        src_addr_q <= '0;
        dst_addr_q <= '0;
        src_port_q <= '0;
        dst_port_q <= '0;
        tcp_off_q  <= '0;
        cnt_q      <= '0;
      end else begin
        pos_q      <= pos_d;
        hw_q       <= hw_d;
        proto_q    <= proto_d;
        src_addr_q <= src_addr_d;
        dst_addr_q <= dst_addr_d;
        src_port_q <= src_port_d;
        dst_port_q <= dst_port_d;
        tcp_off_q  <= tcp_off_d;
        cnt_q      <= cnt_d;
      end
    end
  end

endmodule

### sv/ipvp_out_fifo.sv
// ----------------------------------------------------------------------------
// ipvp_out_fifo
// Four-entry result queue; takes up to two words per cycle, gives one per cycle while ready_i is high.
// ----------------------------------------------------------------------------
module ipvp_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ipvp_pkg::push_t     push_i,
  input  ipvp_pkg::out_word_t pay_i,
  input  ipvp_pkg::out_word_t sum_i,
  output logic                space_o,
  output logic                valid_o,
  input  logic                ready_i,
  output ipvp_pkg::out_word_t data_o
);
  import ipvp_pkg::*;

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  out_word_t        mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, sum_ptr;
  logic [CntW-1:0]  count_q, count_d;
  logic             pop;

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;
  assign space_o = (count_q <= CntW'(Depth - 2));

  assign sum_ptr  = wr_ptr_q + PtrW'(push_i.pay_vld);
  assign wr_ptr_d = wr_ptr_q + PtrW'(push_i.pay_vld) + PtrW'(push_i.sum_vld);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign count_d  = count_q + CntW'(push_i.pay_vld) + CntW'(push_i.sum_vld) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.pay_vld) begin
      mem_q[wr_ptr_q] <= pay_i;
    end
    if (push_i.sum_vld) begin
      mem_q[sum_ptr] <= sum_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### sv/ipv4_tcp_udp_port_filter_parser_unit.sv
// Output: the words for an accepted byte are written into the result queue as the byte
// is accepted. Input rate: one byte per cycle while the sink takes one word per cycle;
// a byte that yields both a payload word and a summary word sends them one after the
// other through the single read port of the four-entry result queue.
// Reset (async, active low) clears frame state and the queue; link_type = 1,
// target_port = 0.
// ----------------------------------------------------------------------------
// ipv4_tcp_udp_port_filter_parser_unit
// IPv4 TCP/UDP header parser with port filter, payload stream and summaries.
// ----------------------------------------------------------------------------
module ipv4_tcp_udp_port_filter_parser_unit #(
  parameter int MaxFrameBytes = ipvp_pkg::MaxFrameBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ipvp_pkg::in_word_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ipvp_pkg::out_word_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ipvp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ipvp_pkg::CfgDataW-1:0] cfg_data_i
);
  import ipvp_pkg::*;

  logic        link_type_q;
  logic [15:0] target_port_q;
  logic        accept;
  logic        space;
  push_t       push;
  out_word_t   pay_word, sum_word;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = space;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_type_q   <= 1'b1;
      target_port_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgLinkType:   link_type_q   <= cfg_data_i[0];
        CfgTargetPort: target_port_q <= cfg_data_i[15:0];
      endcase
    end
  end

  ipvp_parser #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_i         (in_data_i),
    .link_type_i  (link_type_q),
    .target_port_i(target_port_q),
    .push_o       (push),
    .pay_o        (pay_word),
    .sum_o        (sum_word)
  );

  ipvp_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pay_i  (pay_word),
    .sum_i  (sum_word),
    .space_o(space),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (out_data_o)
  );

endmodule

### sv/ipvp_checker.sv
// ----------------------------------------------------------------------------
// ipvp_checker
// Port-level checks of the parser unit, bound to the top level.
// ----------------------------------------------------------------------------
module ipvp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ipvp_pkg::out_word_t out_data_o
);
  import ipvp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_kind |-> out_data_o.status <= StPortMismatch)
    else $error("summary status out of range");

  a_len_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_kind && out_data_o.status != StAccepted
      |-> out_data_o.payload_length == 16'd0)
    else $error("dropped frame reports payload length");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_kind
      |-> out_data_o.status == StAccepted && out_data_o.l4_protocol == 8'd0 &&
          out_data_o.payload_length == 16'd0)
    else $error("payload word carries summary fields");

endmodule

bind ipv4_tcp_udp_port_filter_parser_unit ipvp_checker u_ipvp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
